>>> rtl/assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 8;
    localparam int TAG_W       = 32;
    localparam int OCC_W       = 5;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } spq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/spq_ctrl.sv
// Controller state machine: sequences request capture, execution and result handoff.
`default_nettype none

module spq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spq_pkg::spq_cmd_t      cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
// Datapath: sorted entry cells with parallel compare-and-shift, request and result registers.
`default_nettype none

`include "assert_macros.svh"

module spq_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire spq_pkg::spq_cmd_t            cmd,
    input  wire logic                         mode,
    input  wire logic [spq_pkg::PRIO_W-1:0]   priority_req,
    input  wire logic [spq_pkg::TAG_W-1:0]    tag,
    output logic [1:0]                        status,
    output logic [spq_pkg::PRIO_W-1:0]        out_priority,
    output logic [spq_pkg::TAG_W-1:0]         out_tag,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    // Cell 0 holds the head whenever the queue is not empty; cells at or beyond the count hold stale data.
    logic [PRIO_W-1:0] pri_reg  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] pri_next [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_reg  [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    mode_t             mode_reg;
    logic [PRIO_W-1:0] in_pri_reg;
    logic [TAG_W-1:0]  in_tag_reg;

    status_t           status_reg;
    status_t           status_next;
    logic [PRIO_W-1:0] out_pri_reg;
    logic [PRIO_W-1:0] out_pri_next;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [TAG_W-1:0]  out_tag_next;
    logic [CNT_W-1:0]  occ_reg;

    logic [QUEUE_DEPTH-1:0] ins;
    logic [PRIO_W-1:0]      up_pri [QUEUE_DEPTH];
    logic [TAG_W-1:0]       up_tag [QUEUE_DEPTH];
    logic                   is_full;
    logic                   is_empty;
    logic                   do_enq;
    logic                   do_deq;

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_enq   = cmd.execute && (mode_reg == MODE_ENQ) && !is_full;
    assign do_deq   = cmd.execute && (mode_reg == MODE_DEQ) && !is_empty;

    // Because the cells are sorted, the insert mask is set from the insert
    // position up to the tail slot, so each cell looks at its neighbor only.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CNT_W'(i) < count_reg)
            begin
                ins[i] = (in_pri_reg > pri_reg[i]);
            end
            else
            begin
                ins[i] = (CNT_W'(i) == count_reg);
            end
        end
    end

    always_comb
    begin
        up_pri[0] = in_pri_reg;
        up_tag[0] = in_tag_reg;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            up_pri[i] = ins[i-1] ? pri_reg[i-1] : in_pri_reg;
            up_tag[i] = ins[i-1] ? tag_reg[i-1] : in_tag_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            pri_next[i] = pri_reg[i];
            tag_next[i] = tag_reg[i];
            if (do_enq && ins[i])
            begin
                pri_next[i] = up_pri[i];
                tag_next[i] = up_tag[i];
            end
        end
        if (do_deq)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                pri_next[i] = pri_reg[i+1];
                tag_next[i] = tag_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        status_next  = STATUS_DONE;
        out_pri_next = '0;
        out_tag_next = '0;
        case (mode_reg)
            MODE_ENQ:
            begin
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_DEQ:
            begin
                if (is_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    out_pri_next = pri_reg[0];
                    out_tag_next = tag_reg[0];
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            pri_reg[i] <= pri_next[i];
            tag_reg[i] <= tag_next[i];
        end
        if (cmd.capture)
        begin
            mode_reg   <= mode_t'(mode);
            in_pri_reg <= priority_req;
            in_tag_reg <= tag;
        end
        if (cmd.execute)
        begin
            status_reg  <= status_next;
            out_pri_reg <= out_pri_next;
            out_tag_reg <= out_tag_next;
            occ_reg     <= count_next;
        end
    end

    assign status       = status_reg;
    assign out_priority = out_pri_reg;
    assign out_tag      = out_tag_reg;
    assign occupancy    = OCC_W'(occ_reg);

    `SPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH),
        "entry count exceeds queue depth")

    `SPQ_ASSERT(a_head_sorted, clk, rst_n,
        (count_reg < CNT_W'(2)) || (pri_reg[0] >= pri_reg[1]),
        "head entry has lower priority than the next entry")

    `SPQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, do_enq,
        (count_reg == $past(count_reg) + CNT_W'(1)) && (status_reg == STATUS_DONE),
        "accepted enqueue did not add one entry")

    `SPQ_ASSERT_NEXT(a_empty_reject, clk, rst_n,
        cmd.execute && (mode_reg == MODE_DEQ) && is_empty,
        (status_reg == STATUS_EMPTY) && (count_reg == '0) && (out_tag_reg == '0),
        "dequeue on an empty queue was not rejected")

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: 16 entries, larger priority first, FIFO among equal priorities.
// The request is captured first, then executed into the registered result once that is free.
// A new request is taken only once the previous one has gone through capture and compare-and-shift.
// A request is taken while an earlier result still waits; execution stalls only if it does.
// Reset (asynchronous, active low) empties the queue and drops any pending result.
`default_nettype none

module sorted_priority_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         mode,
    input  wire logic [spq_pkg::PRIO_W-1:0]   priority_req,
    input  wire logic [spq_pkg::TAG_W-1:0]    tag,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic [spq_pkg::PRIO_W-1:0]        out_priority,
    output logic [spq_pkg::TAG_W-1:0]         out_tag,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .priority_req (priority_req),
        .tag          (tag),
        .status       (status),
        .out_priority (out_priority),
        .out_tag      (out_tag),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire
